/* sv/flpq_pkg.sv */
package flpq_pkg;

    // sizing defaults
    localparam int MAX_ENTRIES_DEF = 32;
    localparam int NUM_LEVELS_DEF  = 5;

    // field widths
    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int LEVEL_W  = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;
    localparam int CAP_W    = 6;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(20);

    // register indexes
    localparam logic REG_CAPACITY = 1'b0;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [LEVEL_W-1:0] level_t;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] value;
        level_t                    level;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] front_value;
        level_t                    front_level;
        logic [COUNT_W-1:0]        count;
    } rsp_t;

endpackage

/* sv/flpq_regs.sv */
module flpq_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [flpq_pkg::ADDR_W-1:0]   paddr,
    input  logic [flpq_pkg::DATA_W-1:0]   pwdata,
    output logic [flpq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [flpq_pkg::CAP_W-1:0]    capacity
);
    import flpq_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    logic             reg_index;
    logic             wr_en;

    // word index from the byte address
    assign reg_index = paddr[2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (wr_en && (reg_index == REG_CAPACITY))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            REG_CAPACITY: prdata = DATA_W'(capacity_reg);
            default:      prdata = '0;
        endcase
    end

    assign capacity = capacity_reg;

endmodule

/* sv/five_level_priority_queue.sv */
// Bounded priority queue, levels 1 (most urgent) to NUM_LEVELS, first-in
// first-out within a level.
//
// Command channel: a beat on req is taken at a rising edge with start high
// and busy low. busy is held low, so a command may be issued every cycle.
// Each command is an insert, a delete of the front entry or a peek.
// Result channel: exactly one result per command, shown on rsp for one
// cycle with done high. The command is registered at the accept edge and
// the queue and the result register update at the next edge, one command
// per cycle sustained. The receiver cannot stall; results are never held.
// The queue is a row of MAX_ENTRIES entry registers kept in level order;
// an insert compares its level against every entry in one pass and the row
// shifts open at the slot, a delete shifts the row toward the front.
// Configuration: capacity register at byte address 0 on the APB port; the user
// writes it only while no command is in flight, which the block does not enforce.
// Reset: the queue is empty and capacity is 20; entry contents are not
// cleared, since no entry at or beyond the count ever reaches a result.
module five_level_priority_queue #(
    parameter int MAX_ENTRIES = flpq_pkg::MAX_ENTRIES_DEF,
    parameter int NUM_LEVELS  = flpq_pkg::NUM_LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  flpq_pkg::req_t                req,
    output logic                          done,
    output flpq_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [flpq_pkg::ADDR_W-1:0]   paddr,
    input  logic [flpq_pkg::DATA_W-1:0]   pwdata,
    output logic [flpq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import flpq_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]          capacity;

    // command register
    logic                      cmd_valid_reg;
    req_t                      cmd_reg;

    // queue storage
    logic signed [VALUE_W-1:0] value_reg [MAX_ENTRIES];
    level_t                    level_reg [MAX_ENTRIES];
    logic signed [VALUE_W-1:0] value_next [MAX_ENTRIES];
    level_t                    level_next [MAX_ENTRIES];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    // result register
    logic                      done_reg;
    rsp_t                      rsp_reg;
    rsp_t                      rsp_next;

    level_t                    ins_level;
    logic [CMP_W-1:0]          cap_ext;
    logic [CMP_W-1:0]          eff_cap;
    logic                      is_insert;
    logic                      is_delete;
    logic                      queue_full;
    logic                      queue_empty;
    logic                      do_insert;
    logic                      do_delete;
    logic [MAX_ENTRIES-1:0]    before_slot;

    flpq_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    assign busy = 1'b0;

    // capture the command beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= req;
        end
    end

    // clamp the inserted level into range
    always_comb
    begin
        ins_level = cmd_reg.level;
        if (cmd_reg.level == '0)
        begin
            ins_level = level_t'(1);
        end
        else if (int'(cmd_reg.level) > NUM_LEVELS)
        begin
            ins_level = level_t'(NUM_LEVELS);
        end
    end

    // effective capacity, held between 1 and the queue depth
    always_comb
    begin
        cap_ext = CMP_W'(capacity);
        if (capacity == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(MAX_ENTRIES))
        begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign is_insert   = (cmd_reg.action == ACT_INSERT);
    assign is_delete   = (cmd_reg.action == ACT_DELETE);
    assign queue_full  = (CMP_W'(count_reg) >= eff_cap);
    assign queue_empty = (count_reg == '0);
    assign do_insert   = cmd_valid_reg && is_insert && !queue_full;
    assign do_delete   = cmd_valid_reg && is_delete && !queue_empty;

    // entries that stay ahead of the new one: held and not less urgent
    always_comb
    begin
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            before_slot[k] = (CNT_W'(k) < count_reg) && (level_reg[k] <= ins_level);
        end
    end

    // next contents of each entry
    always_comb
    begin
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            value_next[k] = value_reg[k];
            level_next[k] = level_reg[k];
            if (do_insert)
            begin
                if (!before_slot[k])
                begin
                    if ((k == 0) || before_slot[(k == 0) ? 0 : k - 1])
                    begin
                        value_next[k] = cmd_reg.value;
                        level_next[k] = ins_level;
                    end
                    else
                    begin
                        value_next[k] = value_reg[(k == 0) ? 0 : k - 1];
                        level_next[k] = level_reg[(k == 0) ? 0 : k - 1];
                    end
                end
            end
            else if (do_delete)
            begin
                if (k < MAX_ENTRIES - 1)
                begin
                    value_next[k] = value_reg[(k < MAX_ENTRIES - 1) ? k + 1 : k];
                    level_next[k] = level_reg[(k < MAX_ENTRIES - 1) ? k + 1 : k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_insert || do_delete)
        begin
            for (int k = 0; k < MAX_ENTRIES; k++)
            begin
                value_reg[k] <= value_next[k];
                level_reg[k] <= level_next[k];
            end
        end
    end

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_delete)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // result beat
    always_comb
    begin
        rsp_next.status      = ST_DONE;
        rsp_next.front_value = value_reg[0];
        rsp_next.front_level = level_reg[0];
        rsp_next.count       = COUNT_W'(count_next);
        if (is_insert)
        begin
            if (queue_full)
            begin
                rsp_next.status      = ST_FULL;
                rsp_next.front_value = '0;
                rsp_next.front_level = '0;
            end
            else
            begin
                rsp_next.front_value = cmd_reg.value;
                rsp_next.front_level = ins_level;
            end
        end
        else if (queue_empty)
        begin
            rsp_next.status      = ST_EMPTY;
            rsp_next.front_value = '0;
            rsp_next.front_level = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

/* tb/sv/five_level_priority_queue_tb.sv */
`timescale 1ns / 100ps

module five_level_priority_queue_tb;

    import flpq_pkg::*;

    localparam logic [ADDR_W-1:0]   CAPACITY_ADDR = ADDR_W'(4 * int'(REG_CAPACITY));
    localparam logic [ACTION_W-1:0] ACT_SPARE     = 2'd3;
    localparam int                  LATENCY       = 2;
    localparam int                  PHASES        = 14;
    localparam int                  PHASE_ITEMS   = 125;

    typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_MIXED} bias_t;

    // queue model with a store of pending results
    class pq_scoreboard;
        logic signed [VALUE_W-1:0] held_values[$];
        level_t                    held_levels[$];
        logic [CAP_W-1:0]          capacity;
        rsp_t                      awaited_rsp[$];
        int                        errors;
        int                        checked;
        int                        accepted;
        int                        fulls;
        int                        empties;
        int                        deepest;

        function new();
            capacity = CAPACITY_RESET;
            errors   = 0;
            checked  = 0;
            accepted = 0;
            fulls    = 0;
            empties  = 0;
            deepest  = 0;
        endfunction

        function void set_capacity(input logic [CAP_W-1:0] cap);
            capacity = cap;
        endfunction

        function int pending();
            return awaited_rsp.size();
        endfunction

        // capacity 0 acts as 1, anything past the row size as the row size
        function int room_limit();
            int lim;
            lim = (capacity == 0) ? 1 : int'(capacity);
            if (lim > MAX_ENTRIES_DEF)
                lim = MAX_ENTRIES_DEF;
            return lim;
        endfunction

        // work out the result of one accepted command
        function void note_command(input req_t cmd);
            rsp_t   res;
            level_t lv;
            int     pos;
            res = '0;
            accepted++;
            if (cmd.action == ACT_INSERT)
            begin
                lv = cmd.level;
                if (lv < 1)
                    lv = level_t'(1);
                if (lv > NUM_LEVELS_DEF)
                    lv = level_t'(NUM_LEVELS_DEF);
                if (held_values.size() >= room_limit())
                begin
                    res.status = ST_FULL;
                    fulls++;
                end
                else
                begin
                    // slot goes after every entry of equal or more urgent level
                    pos = 0;
                    foreach (held_levels[k])
                        if (held_levels[k] <= lv)
                            pos = k + 1;
                    held_values.insert(pos, cmd.value);
                    held_levels.insert(pos, lv);
                    res.status      = ST_DONE;
                    res.front_value = cmd.value;
                    res.front_level = lv;
                end
            end
            else if (held_values.size() == 0)
            begin
                res.status = ST_EMPTY;
                empties++;
            end
            else
            begin
                // delete pops the front, peek and the spare code only look
                res.status      = ST_DONE;
                res.front_value = held_values[0];
                res.front_level = held_levels[0];
                if (cmd.action == ACT_DELETE)
                begin
                    void'(held_values.pop_front());
                    void'(held_levels.pop_front());
                end
            end
            res.count = COUNT_W'(held_values.size());
            if (held_values.size() > deepest)
                deepest = held_values.size();
            awaited_rsp.push_back(res);
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // compare one result beat against the oldest expectation
        task check_result(input rsp_t got);
            rsp_t want;
            if (awaited_rsp.size() == 0)
            begin
                report($sformatf("result with nothing pending: %p", got));
            end
            else
            begin
                want = awaited_rsp.pop_front();
                checked++;
                if (got.status !== want.status)
                    report($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.front_value !== want.front_value)
                    report($sformatf("front_value %0d, want %0d",
                                     got.front_value, want.front_value));
                if (got.front_level !== want.front_level)
                    report($sformatf("front_level %0d, want %0d",
                                     got.front_level, want.front_level));
                if (got.count !== want.count)
                    report($sformatf("count %0d, want %0d", got.count, want.count));
            end
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    req_t              req;
    logic              done;
    rsp_t              rsp;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    pq_scoreboard sb = new();
    int           settings_used;

    five_level_priority_queue u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watch both channels at every edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(rsp);
            if (start && !busy)
                sb.note_command(req);
        end
    end

    function automatic req_t make_cmd(input logic [ACTION_W-1:0] act,
                                      input logic [VALUE_W-1:0] val,
                                      input level_t lv);
        req_t cmd;
        cmd.action = act;
        cmd.value  = val;
        cmd.level  = lv;
        return cmd;
    endfunction

    function automatic int draw_gap(input bit steady);
        if (steady)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // one command beat; start stays high when the next beat follows at once
    task automatic send_command(input req_t cmd, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= cmd;
        do
            @(posedge clk);
        while (busy);
    endtask

    // let every pending result land, sampled away from the active edge
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // capacity write with random upper bits, then read back
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        logic [DATA_W-1:0] word;
        word            = $urandom();
        word[CAP_W-1:0] = cap;
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_capacity(cap);
        settings_used++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== DATA_W'(cap))
            sb.report($sformatf("capacity reads %0d, want %0d", prdata, cap));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic req_t random_cmd(input bias_t bias);
        int                  pick;
        int                  ins_lim;
        int                  del_lim;
        int                  peek_lim;
        logic [VALUE_W-1:0]  val;
        level_t              lv;
        logic [ACTION_W-1:0] act;
        case (bias)
            BIAS_FILL:
            begin
                ins_lim = 70; del_lim = 85; peek_lim = 95;
            end
            BIAS_DRAIN:
            begin
                ins_lim = 20; del_lim = 80; peek_lim = 93;
            end
            default:
            begin
                ins_lim = 45; del_lim = 80; peek_lim = 93;
            end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < ins_lim)
            act = ACT_INSERT;
        else if (pick < del_lim)
            act = ACT_DELETE;
        else if (pick < peek_lim)
            act = ACT_PEEK;
        else
            act = ACT_SPARE;
        // mostly random words, now and then an extreme
        case ($urandom_range(0, 19))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7fff_ffff;
            2:       val = 32'h0000_0000;
            3:       val = 32'hffff_ffff;
            default: val = $urandom();
        endcase
        // out-of-range levels now and then
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 2))
                0:       lv = 3'd0;
                1:       lv = 3'd6;
                default: lv = 3'd7;
            endcase
        end
        else
        begin
            lv = level_t'($urandom_range(1, NUM_LEVELS_DEF));
        end
        return make_cmd(act, val, lv);
    endfunction

    initial
    begin
        logic [CAP_W-1:0] phase_cap[PHASES];
        bias_t            phase_bias[PHASES];
        bit               steady;

        phase_cap  = '{6'd1, 6'd0, 6'd32, 6'd3, 6'd63, 6'd20, 6'd2,
                       6'd33, 6'd32, 6'd5, 6'd31, 6'd0, 6'd20, 6'd17};
        phase_bias = '{BIAS_FILL, BIAS_MIXED, BIAS_FILL, BIAS_DRAIN, BIAS_FILL,
                       BIAS_MIXED, BIAS_MIXED, BIAS_FILL, BIAS_MIXED, BIAS_DRAIN,
                       BIAS_FILL, BIAS_MIXED, BIAS_DRAIN, BIAS_MIXED};
        settings_used = 1;

        rst_n   = 1'b0;
        start   = 1'b0;
        req     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, extremes, level clamping, order, drain
        send_command(make_cmd(ACT_PEEK,   32'h1234_5678, 3'd2), 0);
        send_command(make_cmd(ACT_DELETE, 32'h0,         3'd1), 0);
        send_command(make_cmd(ACT_SPARE,  32'hffff_ffff, 3'd7), 0);
        send_command(make_cmd(ACT_INSERT, 32'h7fff_ffff, 3'd3), 0);
        send_command(make_cmd(ACT_INSERT, 32'h8000_0000, 3'd0), draw_gap(1'b0));
        send_command(make_cmd(ACT_INSERT, 32'hffff_ffff, 3'd7), 0);
        send_command(make_cmd(ACT_INSERT, 32'h0000_0000, 3'd5), draw_gap(1'b0));
        send_command(make_cmd(ACT_INSERT, 32'h0000_0001, 3'd1), 0);
        send_command(make_cmd(ACT_INSERT, 32'h5555_5555, 3'd6), 0);
        send_command(make_cmd(ACT_INSERT, 32'haaaa_aaaa, 3'd2), draw_gap(1'b0));
        send_command(make_cmd(ACT_PEEK,   32'h0,         3'd0), 0);
        send_command(make_cmd(ACT_SPARE,  32'h0,         3'd0), 0);
        repeat (8)
            send_command(make_cmd(ACT_DELETE, $urandom(), 3'd4), draw_gap(1'b0));
        send_command(make_cmd(ACT_INSERT, 32'd123, 3'd4), 0);

        // random phases, each under its own capacity setting
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(phase_cap[p]);
            steady = 1'b0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 16 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                send_command(random_cmd(phase_bias[p]), draw_gap(steady));
            end
        end

        wait_drained();
        repeat (LATENCY + 4) @(posedge clk);

        $display("%0d commands under %0d capacity settings, %0d results checked",
                 sb.accepted, settings_used, sb.checked);
        $display("%0d full and %0d empty outcomes, deepest queue %0d entries",
                 sb.fulls, sb.empties, sb.deepest);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // hang guard
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results pending", sb.pending());
        $display("TB_ERROR");
        $finish;
    end

endmodule
